@@ rtl/core/ntp_request_admission_defines.svh @@
// ----------------------------------------------------------------------------
// ntp_request_admission_defines.svh
// Assertion macros shared by the request admission RTL. Synthesis builds
// define SYNTH, which turns every macro into nothing.
// ----------------------------------------------------------------------------
`ifndef NTP_REQUEST_ADMISSION_DEFINES_SVH
`define NTP_REQUEST_ADMISSION_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off while rst is high
`define NRA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nra assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define NRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nra assertion failed");

`else

`define NRA_ASSERT_IMPL(label, ante, cons)
`define NRA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/nra_pkg.sv @@
// ----------------------------------------------------------------------------
// nra_pkg
// Types and constants of the NTP request admission block.
// ----------------------------------------------------------------------------
package nra_pkg;

  // configuration port
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_VERSION  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_VERSION = 8'd3;

  localparam logic [15:0] WINDOW_MS_RST       = 16'd1000;
  localparam logic [7:0]  REQUEST_LIMIT_RST   = 8'd20;
  localparam logic [2:0]  LOWEST_VERSION_RST  = 3'd3;
  localparam logic [2:0]  HIGHEST_VERSION_RST = 3'd4;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT      = 2'd0;
  localparam logic [1:0] VERDICT_BAD_VERSION = 2'd1;
  localparam logic [1:0] VERDICT_NOT_CLIENT  = 2'd2;
  localparam logic [1:0] VERDICT_LIMITED     = 2'd3;

  // NTP header mode for a client request
  localparam logic [2:0] MODE_CLIENT = 3'd3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam int SLOT_W = 3;

  typedef struct packed {
    logic [15:0] window_ms;
    logic [7:0]  request_limit;
    logic [2:0]  lowest_version;
    logic [2:0]  highest_version;
  } cfg_t;

  // one client table entry
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] last_time;
    logic [7:0]  count;
  } entry_t;

endpackage

@@ rtl/core/nra_channels.sv @@
// ----------------------------------------------------------------------------
// nra_channels
// Valid/ready channel interfaces: request items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface nra_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  header_byte;
  logic [31:0] client_addr;
  logic [31:0] now_ms;

  modport source (output valid, header_byte, client_addr, now_ms, input ready);
  modport sink   (input valid, header_byte, client_addr, now_ms, output ready);
endinterface

interface nra_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [2:0] slot;
  logic       new_client;

  modport source (output valid, verdict, slot, new_client, input ready);
  modport sink   (input valid, verdict, slot, new_client, output ready);
endinterface

interface nra_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ntp_request_admission.sv @@
// ----------------------------------------------------------------------------
// ntp_request_admission
// Per-client NTP request admission with a windowed request count limit.
// ----------------------------------------------------------------------------
// One request item is worked on at a time. A request rejected on its header
// (version out of range, or mode not client) goes from the check state
// straight to completion; an admitted request passes the scan, pick and
// rate states, and its time is set by the client table scan: the table
// has a single registered read port and is walked one entry
// per cycle through one shared subtract/compare unit, which then also does
// the window check. A finished result sits in an output register, so the
// next request is taken while it waits; a stalled result holds back only
// the completion of the following request.
`include "ntp_request_admission_defines.svh"

module ntp_request_admission #(
  parameter int ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst,
  nra_cfg_if.sink   cfg,
  nra_req_if.sink   req,
  nra_rsp_if.source rsp
);
  import nra_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_PICK,
    ST_RATE,
    ST_DONE
  } state_t;

  state_t      state;
  cfg_t        regs;

  // captured request
  logic [7:0]  hdr;
  logic [31:0] addr;
  logic [31:0] now;

  // scan bookkeeping
  logic [IW-1:0] scan_idx;
  logic          chk_vld;
  logic [IW-1:0] chk_idx;
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [31:0]   best_age;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] slot_idx;
  logic          fresh;

  // pending result and output register
  logic [1:0]        res_verdict;
  logic [SLOT_W-1:0] res_slot;
  logic              res_new;
  logic              out_valid;
  logic [1:0]        out_verdict;
  logic [SLOT_W-1:0] out_slot;
  logic              out_new;

  // table and shared unit hookup
  logic          tbl_rd_en;
  logic [IW-1:0] tbl_rd_idx;
  entry_t        rd_entry;
  logic          rd_valid;
  logic          tbl_wr_en;
  entry_t        wr_entry;
  logic [31:0]   alu_bound;
  logic          alu_rate;
  logic [31:0]   alu_diff;
  logic          alu_lt;

  // header checks
  logic [2:0]  version;
  logic        bad_version;
  logic        bad_mode;

  // rate rule
  logic        in_window;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_inc;
  logic [7:0]  cnt_new;
  logic        limited;
  logic        scan_step;
  logic [IW-1:0] pick_idx;

  nra_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  nra_table #(.ENTRIES(ENTRIES)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (tbl_rd_en),
    .rd_idx   (tbl_rd_idx),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr_en    (tbl_wr_en),
    .wr_idx   (slot_idx),
    .wr_entry (wr_entry)
  );

  nra_age_unit u_age (
    .now       (now),
    .last      (rd_entry.last_time),
    .bound     (alu_bound),
    .rate_mode (alu_rate),
    .diff      (alu_diff),
    .lt        (alu_lt)
  );

  // handshake ports
  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.verdict    = out_verdict;
  assign rsp.slot       = out_slot;
  assign rsp.new_client = out_new;

  // header field checks
  assign version     = hdr[5:3];
  assign bad_version = (version < regs.lowest_version) || (version > regs.highest_version);
  assign bad_mode    = (hdr[2:0] != MODE_CLIENT);

  // slot choice: own entry, else first free, else oldest
  assign pick_idx = match_found ? match_idx : (free_found ? free_idx : best_idx);

  // table read: walk during the scan, then fetch the chosen slot
  assign tbl_rd_en  = (state == ST_SCAN) || (state == ST_PICK);
  assign tbl_rd_idx = (state == ST_PICK) ? pick_idx : scan_idx;

  // shared unit operands
  assign alu_rate  = (state == ST_RATE);
  assign alu_bound = alu_rate ? {16'd0, regs.window_ms} : best_age;

  // a read result is ready for the scan logic
  assign scan_step = ((state == ST_SCAN) && chk_vld) || (state == ST_SCAN_LAST);

  // window count rule on the fetched entry
  assign in_window = alu_lt;
  assign cnt_base  = (fresh || !in_window) ? 8'd0 : rd_entry.count;
  assign limited   = in_window && (cnt_base >= regs.request_limit);
  assign cnt_inc   = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 8'd1;
  assign cnt_new   = in_window ? cnt_inc : 8'd1;

  // entry update: a taken slot is always written, a limited one only if fresh
  assign tbl_wr_en          = (state == ST_RATE) && (fresh || !limited);
  assign wr_entry.addr      = addr;
  assign wr_entry.last_time = limited ? rd_entry.last_time : now;
  assign wr_entry.count     = limited ? cnt_base : cnt_new;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      chk_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      // the completion step reloads the output register itself
      if (out_valid && rsp.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            hdr   <= req.header_byte;
            addr  <= req.client_addr;
            now   <= req.now_ms;
            state <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          res_slot <= '0;
          res_new  <= 1'b0;
          if (bad_version) begin
            res_verdict <= VERDICT_BAD_VERSION;
            state       <= ST_DONE;
          end else if (bad_mode) begin
            res_verdict <= VERDICT_NOT_CLIENT;
            state       <= ST_DONE;
          end else begin
            scan_idx    <= '0;
            chk_vld     <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            state       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          chk_vld  <= 1'b1;
          chk_idx  <= scan_idx;
          scan_idx <= scan_idx + IW'(1);
          if (scan_idx == LAST_IDX) begin
            state <= ST_SCAN_LAST;
          end
        end

        ST_SCAN_LAST: begin
          chk_vld <= 1'b0;
          state   <= ST_PICK;
        end

        ST_PICK: begin
          slot_idx <= pick_idx;
          fresh    <= !match_found;
          state    <= ST_RATE;
        end

        ST_RATE: begin
          res_verdict <= limited ? VERDICT_LIMITED : VERDICT_ACCEPT;
          res_slot    <= SLOT_W'(slot_idx);
          res_new     <= fresh;
          state       <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_verdict <= res_verdict;
            out_slot    <= res_slot;
            out_new     <= res_new;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase

      // per-entry scan step on the registered read of the entry
      if (scan_step) begin
        if (rd_valid && (rd_entry.addr == addr) && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= chk_idx;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if ((chk_idx == '0) || alu_lt) begin
          best_age <= alu_diff;
          best_idx <= chk_idx;
        end
      end
    end
  end

  // header rejects never touch the table
  `NRA_ASSERT_IMPL(a_reject_no_slot,
    out_valid && ((out_verdict == VERDICT_BAD_VERSION) || (out_verdict == VERDICT_NOT_CLIENT)),
    (out_slot == '0) && !out_new)

  // a known client always gets its own entry back
  `NRA_ASSERT_NEXT(a_match_wins, (state == ST_PICK) && match_found,
    (slot_idx == $past(match_idx)) && !fresh)

  // a new client takes the first free entry when there is one
  `NRA_ASSERT_NEXT(a_free_first, (state == ST_PICK) && !match_found && free_found,
    (slot_idx == $past(free_idx)) && fresh)

  // a result appears only from the completion step
  `NRA_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(state) == ST_DONE)

endmodule

@@ rtl/core/nra_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// nra_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module nra_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  nra_cfg_if.sink       cfg,
  output nra_pkg::cfg_t regs
);
  import nra_pkg::*;

  // writes are always accepted
  assign cfg.ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window_ms       <= WINDOW_MS_RST;
      regs.request_limit   <= REQUEST_LIMIT_RST;
      regs.lowest_version  <= LOWEST_VERSION_RST;
      regs.highest_version <= HIGHEST_VERSION_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WINDOW_MS:       regs.window_ms       <= cfg.data;
        CFG_REQUEST_LIMIT:   regs.request_limit   <= cfg.data[7:0];
        CFG_LOWEST_VERSION:  regs.lowest_version  <= cfg.data[2:0];
        CFG_HIGHEST_VERSION: regs.highest_version <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/nra_table.sv @@
// ----------------------------------------------------------------------------
// nra_table
// Client table: one memory of entries with one write and one registered
// read port, plus a valid flop per entry. An entry never written reads
// with zero time and zero count.
// ----------------------------------------------------------------------------
module nra_table #(
  parameter int ENTRIES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_idx,
  output nra_pkg::entry_t            rd_entry,
  output logic                       rd_valid,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_idx,
  input  nra_pkg::entry_t            wr_entry
);
  import nra_pkg::*;

  entry_t               mem [ENTRIES];
  entry_t               rd_raw;
  logic [ENTRIES-1:0]   valid_bits;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_idx];
    end
  end

  // valid bits: set on the first write of an entry, cleared only by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_bits[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid_bits[rd_idx];
      end
    end
  end

  // unwritten entry reads as its reset value
  always_comb begin
    rd_entry = rd_raw;
    if (!rd_valid) begin
      rd_entry.last_time = '0;
      rd_entry.count     = '0;
    end
  end

endmodule

@@ rtl/core/nra_age_unit.sv @@
// ----------------------------------------------------------------------------
// nra_age_unit
// Shared subtract and compare unit. diff is now - last modulo 2^32.
// In scan mode lt flags bound < diff (older entry found); in rate mode it
// flags diff < bound (request inside the window).
// ----------------------------------------------------------------------------
module nra_age_unit (
  input  logic [31:0] now,
  input  logic [31:0] last,
  input  logic [31:0] bound,
  input  logic        rate_mode,
  output logic [31:0] diff,
  output logic        lt
);

  logic [31:0] cmp_a;
  logic [31:0] cmp_b;

  assign diff = now - last;

  // one magnitude comparator, operands swapped by mode
  assign cmp_a = rate_mode ? diff  : bound;
  assign cmp_b = rate_mode ? bound : diff;
  assign lt    = cmp_a < cmp_b;

endmodule

@@ tb/ntp_request_admission_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_request_admission_tb
// Drives NTP request items into the admission block and checks every
// verdict against a cycle-free predictor of the client table and the rate
// limit. A short directed part covers header rejection order, slot
// allocation and eviction ties, and time wrap. Random phases under several
// register settings follow, including zero window, zero limit and an empty
// version range. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module ntp_request_admission_tb;
  import nra_pkg::*;

  localparam int ENTRIES = 8;
  localparam int POOL_SIZE = 12;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [31:0] client_addr;
    logic [31:0] now_ms;
  } ntp_request_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [SLOT_W-1:0] slot;
    logic              new_client;
  } admission_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nra_cfg_if cfg_ch ();
  nra_req_if req_ch ();
  nra_rsp_if rsp_ch ();

  ntp_request_admission #(.ENTRIES(ENTRIES)) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and the client table
  logic [15:0] win_reg   = WINDOW_MS_RST;
  logic [7:0]  limit_reg = REQUEST_LIMIT_RST;
  logic [2:0]  lo_ver    = LOWEST_VERSION_RST;
  logic [2:0]  hi_ver    = HIGHEST_VERSION_RST;

  logic [31:0] tbl_addr  [ENTRIES];
  logic [31:0] tbl_last  [ENTRIES] = '{default: '0};
  logic [7:0]  tbl_count [ENTRIES] = '{default: '0};
  bit          tbl_valid [ENTRIES] = '{default: 1'b0};

  ntp_request_t pending_reqs [$];
  admission_t   expected_verdicts [$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          no_idle = 1'b0;
  logic        req_fire = 1'b0;
  int unsigned req_gap = 0;
  int unsigned rsp_stall = 0;

  // random stimulus state
  logic [31:0] client_pool [POOL_SIZE];
  int unsigned pool_n = 4;
  logic [31:0] stamp_ms = '0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  // admission decision for one request; updates the table copy
  function automatic admission_t admit_request(input ntp_request_t r);
    admission_t  res;
    logic [2:0]  ver;
    logic [2:0]  mode;
    bit          found;
    bit          free_found;
    int          s;
    logic [31:0] age;
    logic [31:0] best_age;
    logic [31:0] d;
    bit          in_window;

    ver = r.header_byte[5:3];
    mode = r.header_byte[2:0];
    res = '0;
    res.verdict = VERDICT_ACCEPT;
    found = 1'b0;
    free_found = 1'b0;
    s = 0;
    best_age = '0;
    if (ver < lo_ver || ver > hi_ver) begin
      res.verdict = VERDICT_BAD_VERSION;
    end else if (mode != MODE_CLIENT) begin
      res.verdict = VERDICT_NOT_CLIENT;
    end else begin
      // existing client, else first free entry, else oldest (lowest index on tie)
      for (int i = 0; i < ENTRIES; i++)
        if (!found && tbl_valid[i] && tbl_addr[i] == r.client_addr) begin
          found = 1'b1;
          s = i;
        end
      if (!found) begin
        for (int i = 0; i < ENTRIES; i++)
          if (!free_found && !tbl_valid[i]) begin
            free_found = 1'b1;
            s = i;
          end
        if (!free_found)
          for (int i = 0; i < ENTRIES; i++) begin
            age = r.now_ms - tbl_last[i];
            if (i == 0 || age > best_age) begin
              best_age = age;
              s = i;
            end
          end
        tbl_addr[s] = r.client_addr;
        tbl_count[s] = '0;
        tbl_valid[s] = 1'b1;
      end
      // window check, modulo 2^32
      d = r.now_ms - tbl_last[s];
      in_window = d < {16'd0, win_reg};
      if (!in_window)
        tbl_count[s] = '0;
      if (tbl_count[s] >= limit_reg && in_window) begin
        res.verdict = VERDICT_LIMITED;
      end else begin
        if (!in_window)
          tbl_count[s] = 8'd1;
        else if (tbl_count[s] != COUNT_MAX)
          tbl_count[s] = tbl_count[s] + 8'd1;
        tbl_last[s] = r.now_ms;
      end
      res.slot = s[SLOT_W-1:0];
      res.new_client = !found;
    end
    return res;
  endfunction

  // idle length: mostly none, a few short, rarely long
  function automatic int unsigned pick_gap(input int unsigned busy_pct);
    int unsigned r;
    if ($urandom_range(0, 99) >= busy_pct)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    if (r < 95)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] ntp_header(input logic [1:0] leap, input logic [2:0] ver,
                                            input logic [2:0] mode);
    return {leap, ver, mode};
  endfunction

  task automatic queue_request(input logic [7:0] hdr, input logic [31:0] addr,
                               input logic [31:0] now);
    ntp_request_t r;
    r.header_byte = hdr;
    r.client_addr = addr;
    r.now_ms = now;
    pending_reqs.push_back(r);
  endtask

  // mostly well-formed requests from a small client pool with a moving clock
  function automatic ntp_request_t random_request();
    ntp_request_t r;
    int unsigned  pick;
    int unsigned  span;

    pick = $urandom_range(0, 99);
    span = 32'(win_reg) / (pool_n * (32'(limit_reg) + 1)) + 1;
    if (pick < 4)
      stamp_ms = $urandom;
    else if (pick < 20)
      stamp_ms = stamp_ms + $urandom_range(0, 2 * 32'(win_reg) + 2);
    else
      stamp_ms = stamp_ms + $urandom_range(0, span);
    r.now_ms = stamp_ms;

    if (lo_ver <= hi_ver && $urandom_range(0, 99) < 85)
      r.header_byte = ntp_header(2'($urandom), 3'($urandom_range(lo_ver, hi_ver)), MODE_CLIENT);
    else
      r.header_byte = 8'($urandom);

    if ($urandom_range(0, 99) < 92)
      r.client_addr = client_pool[$urandom_range(0, pool_n - 1)];
    else
      r.client_addr = $urandom;
    return r;
  endfunction

  // wait until no request is queued, in flight or awaiting its result
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one register setting followed by a batch of random requests
  task automatic run_phase(input logic [15:0] win, input logic [7:0] lim,
                           input logic [2:0] lo, input logic [2:0] hi,
                           input int unsigned clients, input int unsigned n_items,
                           input bit steady);
    wait_drained();
    write_reg(CFG_WINDOW_MS, win);
    write_reg(CFG_REQUEST_LIMIT, {8'd0, lim});
    write_reg(CFG_LOWEST_VERSION, {13'd0, lo});
    write_reg(CFG_HIGHEST_VERSION, {13'd0, hi});
    pool_n = clients;
    no_idle = steady;
    if ($urandom_range(0, 3) == 0)
      stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else
      stamp_ms = $urandom;
    repeat (n_items)
      pending_reqs.push_back(random_request());
  endtask

  // request driver
  always @(negedge clk) begin : req_driver
    ntp_request_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_gap > 0) begin
        req_ch.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        item = pending_reqs.pop_front();
        req_ch.header_byte <= item.header_byte;
        req_ch.client_addr <= item.client_addr;
        req_ch.now_ms <= item.now_ms;
        req_ch.valid <= 1'b1;
        req_gap <= no_idle ? 0 : pick_gap(30);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_stall <= no_idle ? 0 : pick_gap(20);
    end
  end

  // monitor: register writes, accepted requests and results
  always @(posedge clk) begin : monitor
    admission_t   want;
    ntp_request_t seen;
    req_fire <= req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WINDOW_MS:       win_reg = cfg_ch.data;
          CFG_REQUEST_LIMIT:   limit_reg = cfg_ch.data[7:0];
          CFG_LOWEST_VERSION:  lo_ver = cfg_ch.data[2:0];
          CFG_HIGHEST_VERSION: hi_ver = cfg_ch.data[2:0];
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = expected_verdicts.pop_front();
          if (rsp_ch.verdict !== want.verdict)
            flag_mismatch($sformatf("verdict got %0d want %0d", rsp_ch.verdict, want.verdict));
          if (rsp_ch.slot !== want.slot)
            flag_mismatch($sformatf("slot got %0d want %0d", rsp_ch.slot, want.slot));
          if (rsp_ch.new_client !== want.new_client)
            flag_mismatch($sformatf("new_client got %0b want %0b",
                                    rsp_ch.new_client, want.new_client));
        end
        results_seen++;
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.header_byte = req_ch.header_byte;
        seen.client_addr = req_ch.client_addr;
        seen.now_ms = req_ch.now_ms;
        expected_verdicts.push_back(admit_request(seen));
      end
    end
  end

  // stimulus and end of run
  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.header_byte = '0;
    req_ch.client_addr = '0;
    req_ch.now_ms = '0;
    rsp_ch.ready = 1'b0;

    client_pool[0] = 32'h0000_0000;
    client_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++)
      client_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // header rejection: version bounds, version checked before mode
    queue_request(ntp_header(2'd0, 3'd0, 3'd0), 32'h0, 32'h0);
    queue_request(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(ntp_header(2'd2, 3'd2, MODE_CLIENT), 32'h1, 32'h1);
    queue_request(ntp_header(2'd1, 3'd3, 3'd0), 32'h2, 32'h2);
    queue_request(ntp_header(2'd0, 3'd4, 3'd7), 32'h3, 32'h3);
    // first clients, address and time extremes
    queue_request(ntp_header(2'd3, 3'd4, MODE_CLIENT), 32'h0, 32'h0);
    queue_request(ntp_header(2'd0, 3'd3, MODE_CLIENT), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the table with equal last times
    queue_request(ntp_header(2'd0, 3'd3, MODE_CLIENT), 32'h0, 32'd100);
    queue_request(ntp_header(2'd0, 3'd3, MODE_CLIENT), 32'hFFFF_FFFF, 32'd100);
    for (int i = 2; i < ENTRIES; i++)
      queue_request(ntp_header(2'd0, 3'd4, MODE_CLIENT), 32'h0A00_0000 + i, 32'd100);
    // eviction on a full table: age tie goes to slot 0, then the next oldest
    queue_request(ntp_header(2'd1, 3'd3, MODE_CLIENT), 32'hC0A8_0001, 32'd1300);
    queue_request(ntp_header(2'd1, 3'd3, MODE_CLIENT), 32'hC0A8_0002, 32'd1300);
    // time wrap inside one window
    queue_request(ntp_header(2'd0, 3'd4, MODE_CLIENT), 32'hC0A8_0001, 32'hFFFF_FFF0);
    queue_request(ntp_header(2'd0, 3'd4, MODE_CLIENT), 32'hC0A8_0001, 32'h0000_0010);

    run_phase(16'd50, 8'd3, 3'd0, 3'd7, 4, 60, 1'b0);
    run_phase(16'hFFFF, 8'hFF, 3'd4, 3'd4, 12, 60, 1'b1);
    // zero window: every admitted request starts a fresh count
    run_phase(16'd0, 8'd0, 3'd7, 3'd7, 6, 40, 1'b0);
    // empty version range
    run_phase(16'd1, 8'd1, 3'd5, 3'd2, 8, 20, 1'b0);
    // zero limit: anything inside the window is limited
    run_phase(16'd200, 8'd0, 3'd0, 3'd0, 5, 40, 1'b0);
    run_phase(WINDOW_MS_RST, REQUEST_LIMIT_RST, LOWEST_VERSION_RST, HIGHEST_VERSION_RST,
              10, 60, 1'b0);
    repeat (2) begin
      logic [2:0] lo;
      lo = 3'($urandom_range(0, 3));
      run_phase(16'($urandom_range(1, 400)), 8'($urandom_range(1, 6)), lo,
                3'($urandom_range(lo, 7)), $urandom_range(3, 10), 60, 1'b0);
    end

    wait_drained();
    repeat (3 * ENTRIES + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_verdicts.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
